[rtl/rgba_to_tiff_sample_packer_top_defines.svh]
// Assertion macros shared by the RTL that carries checks.
`ifndef RGBA_TO_TIFF_SAMPLE_PACKER_TOP_DEFINES_SVH
`define RGBA_TO_TIFF_SAMPLE_PACKER_TOP_DEFINES_SVH

// Check on every clock edge outside reset.
`define RTSP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define RTSP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/rtsp_pkg.sv]
`default_nettype none

package rtsp_pkg;

    localparam int MODE_W    = 3;
    localparam int WIDTH_W   = 13;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 13;
    localparam int LUMA_W    = 18;

    typedef enum logic [MODE_W-1:0] {
        MODE_RGBA     = 3'd0,
        MODE_RGB      = 3'd1,
        MODE_GRAY8    = 3'd2,
        MODE_GRAY1    = 3'd3,
        MODE_PALETTE8 = 3'd4,
        MODE_PALETTE4 = 3'd5
    } mode_t;

    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_MODE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 1'd1;

    localparam logic [WIDTH_W-1:0] IMAGE_WIDTH_RESET = 13'd1;

    // Luma weights; luma/1000 >= 128 is tested as weighted sum >= 128000
    localparam logic [LUMA_W-1:0] LUMA_R         = 18'd299;
    localparam logic [LUMA_W-1:0] LUMA_G         = 18'd587;
    localparam logic [LUMA_W-1:0] LUMA_B         = 18'd114;
    localparam logic [LUMA_W-1:0] LUMA_THRESHOLD = 18'(128 * 1000);

    localparam logic [7:0] GRAY1_MSB    = 8'h80;
    localparam logic [7:0] NIBBLE_MASK  = 8'h0F;

    localparam logic [2:0] COUNT_ONE   = 3'd1;
    localparam logic [2:0] COUNT_THREE = 3'd3;
    localparam logic [2:0] COUNT_FOUR  = 3'd4;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pixel_t;

    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [7:0] byte3;
        logic [2:0] byte_count;
        logic       row_end;
        logic       gray_mismatch;
    } result_t;

    typedef struct packed {
        logic [MODE_W-1:0]  pixel_mode;
        logic [WIDTH_W-1:0] image_width;
    } cfg_t;

endpackage

`default_nettype wire

[rtl/rtsp_stream_if.sv]
`default_nettype none

interface rtsp_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/rtsp_cfg_regs.sv]
`default_nettype none

module rtsp_cfg_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [rtsp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rtsp_pkg::CFG_DAT_W-1:0]  cfg_data,
    output rtsp_pkg::cfg_t                       cfg
);

    rtsp_pkg::cfg_t cfg_reg;
    rtsp_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                rtsp_pkg::REG_PIXEL_MODE:
                    cfg_next.pixel_mode = cfg_data[rtsp_pkg::MODE_W-1:0];
                rtsp_pkg::REG_IMAGE_WIDTH:
                    cfg_next.image_width = cfg_data[rtsp_pkg::WIDTH_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pixel_mode  <= rtsp_pkg::MODE_RGBA;
            cfg_reg.image_width <= rtsp_pkg::IMAGE_WIDTH_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[rtl/rtsp_in_stage.sv]
`default_nettype none

module rtsp_in_stage (
    input  wire logic     clk,
    input  wire logic     rst_n,
    rtsp_stream_if.sink   pixel,
    rtsp_stream_if.source staged
);

    logic                 valid_reg;
    logic                 valid_next;
    rtsp_pkg::pixel_t     data_reg;
    logic                 take;

    // Accept when empty or when the held pixel moves on this cycle
    assign pixel.ready = !valid_reg || staged.ready;
    assign take        = pixel.valid && pixel.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (pixel.ready)
        begin
            valid_next = pixel.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg <= pixel.data;
        end
    end

    assign staged.valid = valid_reg;
    assign staged.data  = data_reg;

endmodule

`default_nettype wire

[rtl/rtsp_pack.sv]
`default_nettype none

module rtsp_pack #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire rtsp_pkg::cfg_t cfg,
    rtsp_stream_if.sink   staged,
    rtsp_stream_if.source result
);

    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int MAXW_W = $clog2(MAX_WIDTH + 1);
    localparam int CMP_A  = (COL_W + 1 > rtsp_pkg::WIDTH_W) ? COL_W + 1 : rtsp_pkg::WIDTH_W;
    localparam int CMP_W  = (CMP_A > MAXW_W) ? CMP_A : MAXW_W;

    logic [COL_W-1:0]            column_reg;
    logic [COL_W-1:0]            column_next;
    logic [7:0]                  pack_byte_reg;
    logic [7:0]                  pack_byte_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    rtsp_pkg::result_t           result_reg;
    rtsp_pkg::result_t           result_next;

    logic                        take;
    logic                        emit;
    logic                        last;
    logic [CMP_W-1:0]            width_ext;
    logic [CMP_W-1:0]            eff_width;
    logic [2:0]                  slot;
    logic [rtsp_pkg::LUMA_W-1:0] luma_sum;
    logic                        luma_high;
    logic [7:0]                  base_byte;
    rtsp_pkg::pixel_t            px;

    assign px           = staged.data;
    assign staged.ready = !out_valid_reg || result.ready;
    assign take         = staged.valid && staged.ready;

    // Row end: clamp width to 1..MAX_WIDTH, then test column + 1
    always_comb
    begin
        width_ext = CMP_W'(cfg.image_width);
        if (width_ext == '0)
        begin
            eff_width = CMP_W'(1);
        end
        else if (width_ext > CMP_W'(MAX_WIDTH))
        begin
            eff_width = CMP_W'(MAX_WIDTH);
        end
        else
        begin
            eff_width = width_ext;
        end
    end

    assign last = (CMP_W'(column_reg) + CMP_W'(1)) >= eff_width;
    assign slot = 3'(column_reg);

    assign luma_sum  = {10'd0, px.red}   * rtsp_pkg::LUMA_R
                     + {10'd0, px.green} * rtsp_pkg::LUMA_G
                     + {10'd0, px.blue}  * rtsp_pkg::LUMA_B;
    assign luma_high = luma_sum >= rtsp_pkg::LUMA_THRESHOLD;

    always_comb
    begin
        emit           = 1'b1;
        pack_byte_next = pack_byte_reg;
        column_next    = last ? '0 : column_reg + COL_W'(1);
        base_byte      = 8'd0;
        result_next    = '0;
        result_next.row_end = last;

        case (cfg.pixel_mode)
            rtsp_pkg::MODE_RGBA:
            begin
                result_next.byte0      = px.red;
                result_next.byte1      = px.green;
                result_next.byte2      = px.blue;
                result_next.byte3      = px.alpha;
                result_next.byte_count = rtsp_pkg::COUNT_FOUR;
            end
            rtsp_pkg::MODE_RGB:
            begin
                result_next.byte0      = px.red;
                result_next.byte1      = px.green;
                result_next.byte2      = px.blue;
                result_next.byte_count = rtsp_pkg::COUNT_THREE;
            end
            rtsp_pkg::MODE_GRAY8:
            begin
                result_next.byte0         = px.red;
                result_next.byte_count    = rtsp_pkg::COUNT_ONE;
                result_next.gray_mismatch = (px.red != px.green) || (px.green != px.blue);
            end
            rtsp_pkg::MODE_GRAY1:
            begin
                // Start fresh on bit 7, fill MSB first
                base_byte = (slot == 3'd0) ? 8'd0 : pack_byte_reg;
                if (luma_high)
                begin
                    base_byte = base_byte | (rtsp_pkg::GRAY1_MSB >> slot);
                end
                result_next.byte0      = base_byte;
                result_next.byte_count = rtsp_pkg::COUNT_ONE;
                emit                   = (slot == 3'd7) || last;
                pack_byte_next         = emit ? 8'd0 : base_byte;
            end
            rtsp_pkg::MODE_PALETTE8:
            begin
                result_next.byte0      = px.red;
                result_next.byte_count = rtsp_pkg::COUNT_ONE;
            end
            rtsp_pkg::MODE_PALETTE4:
            begin
                if (!column_reg[0])
                begin
                    base_byte = {px.red[3:0], 4'd0};
                end
                else
                begin
                    base_byte = pack_byte_reg | (px.red & rtsp_pkg::NIBBLE_MASK);
                end
                result_next.byte0      = base_byte;
                result_next.byte_count = rtsp_pkg::COUNT_ONE;
                emit                   = column_reg[0] || last;
                pack_byte_next         = emit ? 8'd0 : base_byte;
            end
            default:
            begin
                // Unused mode codes: drop the pixel, hold the state
                emit        = 1'b0;
                column_next = column_reg;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (staged.ready)
        begin
            out_valid_next = take && emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg    <= '0;
            pack_byte_reg <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                column_reg    <= column_next;
                pack_byte_reg <= pack_byte_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            result_reg <= result_next;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = result_reg;

endmodule

`default_nettype wire

[rtl/rgba_to_tiff_sample_packer_top.sv]
`default_nettype none
`include "rgba_to_tiff_sample_packer_top_defines.svh"

// RGBA pixel packer. Takes one RGBA8 pixel per clock in raster order and
// returns up to four output bytes per result in the selected format: RGBA,
// RGB, gray8 (with a flag when red, green and blue differ), gray1 by luma
// threshold, palette8 or palette4. A pixel is held in an input register and
// then packed into the result register, which offers its result; one pixel
// is taken every clock as long as results are taken, and a held result
// stalls the input once both registers are full. Gray1 yields a result every
// eighth pixel and palette4 every second pixel, with a zero-padded partial
// byte at row end.
// pixel_mode and image_width are written through the cfg port while the
// block is idle; writes do not reset the column or the partial byte.
module rgba_to_tiff_sample_packer_top #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [rtsp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rtsp_pkg::CFG_DAT_W-1:0]  cfg_data,
    rtsp_stream_if.sink                          pixel,
    rtsp_stream_if.source                        result
);

    rtsp_pkg::cfg_t cfg;

    rtsp_stream_if #(.payload_t(rtsp_pkg::pixel_t)) staged ();

    rtsp_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rtsp_in_stage u_in_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pixel),
        .staged (staged)
    );

    rtsp_pack #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_pack (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .staged (staged),
        .result (result)
    );

    `RTSP_ASSERT(a_result_from_pixel, $rose(result.valid) |-> $past(staged.valid && staged.ready), "result without a packed pixel")
    `RTSP_ASSERT(a_stall_means_full, !pixel.ready |-> (staged.valid && result.valid && !result.ready), "input stalled while a stage is free")
    `RTSP_ASSERT(a_mismatch_single, (result.valid && result.data.gray_mismatch) |-> (result.data.byte_count == rtsp_pkg::COUNT_ONE), "gray mismatch on a multi-byte result")
    `RTSP_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !result.valid, "result valid straight after reset")

endmodule

`default_nettype wire

[verif/rgba_to_tiff_sample_packer_checker.sv]
`timescale 1ns / 100ps

module rgba_to_tiff_sample_packer_checker #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [rtsp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rtsp_pkg::CFG_DAT_W-1:0] cfg_data,
    input  logic                           pixel_valid,
    input  logic                           pixel_ready,
    input  rtsp_pkg::pixel_t               pixel_data,
    input  logic                           result_valid,
    input  logic                           result_ready,
    input  rtsp_pkg::result_t              result_data,
    output int                             failures,
    output int                             outstanding
);

    localparam int unsigned LUMA_SCALE = 1000;
    localparam int unsigned LUMA_CUT   = 128;

    logic [rtsp_pkg::MODE_W-1:0]  fmt_mode;
    logic [rtsp_pkg::WIDTH_W-1:0] row_width;
    int unsigned                  column;
    logic [7:0]                   partial_byte;
    rtsp_pkg::result_t            expected_words[$];
    rtsp_pkg::result_t            predicted;
    rtsp_pkg::result_t            oldest;

    // Work out the output word for one pixel; returns 0 when the pixel only
    // adds to a partial byte or the mode is unused.
    function automatic bit pack_pixel(input rtsp_pkg::pixel_t px,
                                      output rtsp_pkg::result_t res);
        int unsigned eff_width;
        int unsigned luma;
        int unsigned slot;
        bit          last;
        bit          emit;
        res  = '0;
        emit = 1'b1;
        if (fmt_mode > rtsp_pkg::MODE_PALETTE4)
            return 1'b0;
        if (row_width == 0)
            eff_width = 1;
        else if (row_width > MAX_WIDTH)
            eff_width = MAX_WIDTH;
        else
            eff_width = row_width;
        last = (column + 1 >= eff_width);
        case (fmt_mode)
            rtsp_pkg::MODE_RGBA:
            begin
                res.byte0      = px.red;
                res.byte1      = px.green;
                res.byte2      = px.blue;
                res.byte3      = px.alpha;
                res.byte_count = rtsp_pkg::COUNT_FOUR;
            end
            rtsp_pkg::MODE_RGB:
            begin
                res.byte0      = px.red;
                res.byte1      = px.green;
                res.byte2      = px.blue;
                res.byte_count = rtsp_pkg::COUNT_THREE;
            end
            rtsp_pkg::MODE_GRAY8:
            begin
                res.byte0         = px.red;
                res.byte_count    = rtsp_pkg::COUNT_ONE;
                res.gray_mismatch = (px.red != px.green) || (px.green != px.blue);
            end
            rtsp_pkg::MODE_GRAY1:
            begin
                slot = column % 8;
                luma = (int'(rtsp_pkg::LUMA_R) * px.red + int'(rtsp_pkg::LUMA_G) * px.green
                        + int'(rtsp_pkg::LUMA_B) * px.blue) / LUMA_SCALE;
                // the first bit of a byte starts it afresh
                if (slot == 0)
                    partial_byte = '0;
                if (luma >= LUMA_CUT)
                    partial_byte = partial_byte | (rtsp_pkg::GRAY1_MSB >> slot);
                if (slot == 7 || last)
                begin
                    res.byte0      = partial_byte;
                    res.byte_count = rtsp_pkg::COUNT_ONE;
                    partial_byte   = '0;
                end
                else
                    emit = 1'b0;
            end
            rtsp_pkg::MODE_PALETTE8:
            begin
                res.byte0      = px.red;
                res.byte_count = rtsp_pkg::COUNT_ONE;
            end
            rtsp_pkg::MODE_PALETTE4:
            begin
                if (column % 2 == 0)
                    partial_byte = (px.red & rtsp_pkg::NIBBLE_MASK) << 4;
                else
                    partial_byte = partial_byte | (px.red & rtsp_pkg::NIBBLE_MASK);
                if (column % 2 == 1 || last)
                begin
                    res.byte0      = partial_byte;
                    res.byte_count = rtsp_pkg::COUNT_ONE;
                    partial_byte   = '0;
                end
                else
                    emit = 1'b0;
            end
            default:
                emit = 1'b0;
        endcase
        column      = last ? 0 : column + 1;
        res.row_end = last;
        return emit;
    endfunction

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            failures++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_mode     = rtsp_pkg::MODE_RGBA;
            row_width    = rtsp_pkg::IMAGE_WIDTH_RESET;
            column       = 0;
            partial_byte = '0;
            expected_words.delete();
            failures     = 0;
            outstanding  = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == rtsp_pkg::REG_PIXEL_MODE)
                    fmt_mode = cfg_data[rtsp_pkg::MODE_W-1:0];
                else if (cfg_index == rtsp_pkg::REG_IMAGE_WIDTH)
                    row_width = cfg_data[rtsp_pkg::WIDTH_W-1:0];
            end
            if (pixel_valid && pixel_ready)
            begin
                if (pack_pixel(pixel_data, predicted))
                    expected_words = {expected_words, predicted};
            end
            if (result_valid && result_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("result transaction with nothing expected: 0x%0h", result_data);
                    failures++;
                end
                else
                begin
                    oldest = expected_words.pop_front();
                    check_field("byte0", oldest.byte0, result_data.byte0);
                    check_field("byte1", oldest.byte1, result_data.byte1);
                    check_field("byte2", oldest.byte2, result_data.byte2);
                    check_field("byte3", oldest.byte3, result_data.byte3);
                    check_field("byte_count", 8'(oldest.byte_count),
                                8'(result_data.byte_count));
                    check_field("row_end", 8'(oldest.row_end), 8'(result_data.row_end));
                    check_field("gray_mismatch", 8'(oldest.gray_mismatch),
                                8'(result_data.gray_mismatch));
                end
            end
            outstanding = expected_words.size();
        end
    end

endmodule

[verif/rgba_to_tiff_sample_packer_top_tb.sv]
`timescale 1ns / 100ps

module rgba_to_tiff_sample_packer_top_tb;

    localparam int MAX_WIDTH      = 4096;
    localparam int ITEM_TARGET    = 650;
    localparam int MAX_GAP        = 12;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_write;
    logic [rtsp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [rtsp_pkg::CFG_DAT_W-1:0] cfg_data;
    int                             failures;
    int                             outstanding;
    int                             idle_cycles = 0;
    int                             pixels_sent;
    bit                             no_gaps;

    rtsp_stream_if #(.payload_t(rtsp_pkg::pixel_t))  pixel_ch ();
    rtsp_stream_if #(.payload_t(rtsp_pkg::result_t)) result_ch ();

    rgba_to_tiff_sample_packer_top #(
        .MAX_WIDTH (MAX_WIDTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pixel_ch),
        .result    (result_ch)
    );

    rgba_to_tiff_sample_packer_checker #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_ch.valid),
        .pixel_ready  (pixel_ch.ready),
        .pixel_data   (pixel_ch.data),
        .result_valid (result_ch.valid),
        .result_ready (result_ch.ready),
        .result_data  (result_ch.data),
        .failures     (failures),
        .outstanding  (outstanding)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Drop valid, let every expected word drain, then allow for pixels that
    // leave no word behind.
    task automatic wait_idle();
        pixel_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Entered and left at a falling edge; hold the write until nothing is in flight.
    task automatic write_reg(input logic [rtsp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rtsp_pkg::CFG_DAT_W-1:0] value);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_format(input logic [rtsp_pkg::MODE_W-1:0] mode, input int width);
        // upper data bits are don't-care for the mode register
        write_reg(rtsp_pkg::REG_PIXEL_MODE,
                  {(rtsp_pkg::CFG_DAT_W - rtsp_pkg::MODE_W)'($urandom), mode});
        write_reg(rtsp_pkg::REG_IMAGE_WIDTH, rtsp_pkg::CFG_DAT_W'(width));
    endtask

    task automatic send_pixel(input rtsp_pkg::pixel_t px);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            pixel_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pixel_ch.valid <= 1'b1;
        pixel_ch.data  <= px;
        do
            @(posedge clk);
        while (!pixel_ch.ready);
        @(negedge clk);
    endtask

    function automatic rtsp_pkg::pixel_t random_pixel(input logic [rtsp_pkg::MODE_W-1:0] mode);
        rtsp_pkg::pixel_t px;
        logic [7:0]       level;
        px = rtsp_pkg::pixel_t'($urandom);
        level = 8'($urandom_range(120, 136));
        if (mode == rtsp_pkg::MODE_GRAY8 && $urandom_range(0, 1) == 1)
        begin
            px.green = px.red;
            px.blue  = px.red;
        end
        else if (mode == rtsp_pkg::MODE_GRAY1 && $urandom_range(0, 2) == 0)
        begin
            // equal channels give luma equal to the level: straddle the threshold
            px.red   = level;
            px.green = level;
            px.blue  = level;
        end
        return px;
    endfunction

    task automatic run_phase(input logic [rtsp_pkg::MODE_W-1:0] mode, input int width,
                             input int count);
        set_format(mode, width);
        repeat (count)
        begin
            send_pixel(random_pixel(mode));
            if (mode <= rtsp_pkg::MODE_PALETTE4)
                pixels_sent++;
        end
        wait_idle();
    endtask

    always @(posedge clk)
    begin
        if ((pixel_ch.valid && pixel_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : result_sink
        int stall;
        int taken;
        taken = 0;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            // hold off long enough for the block to fill and stall its input
            if (taken == 50 || taken == 250)
                stall = LONG_HOLD;
            else
                stall = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_ch.valid);
            taken++;
            @(negedge clk);
        end
    end

    initial
    begin : pixel_source
        logic [rtsp_pkg::MODE_W-1:0] mode;
        int                          width;
        int                          count;
        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        pixel_ch.valid = 1'b0;
        pixel_ch.data  = '0;
        no_gaps        = 1'b0;
        pixels_sent    = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_format(rtsp_pkg::MODE_RGBA, 3);
        send_pixel(rtsp_pkg::pixel_t'(32'h0000_0000));
        send_pixel(rtsp_pkg::pixel_t'(32'hFFFF_FFFF));
        send_pixel(rtsp_pkg::pixel_t'(32'h5AA5_3CC3));
        set_format(rtsp_pkg::MODE_RGB, 2);
        send_pixel(rtsp_pkg::pixel_t'(32'h1234_5678));
        send_pixel(rtsp_pkg::pixel_t'(32'hFEDC_BA98));
        set_format(rtsp_pkg::MODE_GRAY8, 4);
        send_pixel(rtsp_pkg::pixel_t'(32'h8080_8080));
        send_pixel(rtsp_pkg::pixel_t'(32'h0102_0100));
        send_pixel(rtsp_pkg::pixel_t'(32'h0505_06FF));
        send_pixel(rtsp_pkg::pixel_t'(32'h0908_0810));
        wait_idle();
        // unused mode codes: pixels are swallowed and leave the state alone
        set_format(rtsp_pkg::MODE_PALETTE4 + 3'd1, 4);
        send_pixel(rtsp_pkg::pixel_t'(32'hFFFF_FFFF));
        write_reg(rtsp_pkg::REG_PIXEL_MODE,
                  rtsp_pkg::CFG_DAT_W'(rtsp_pkg::MODE_PALETTE4 + 3'd2));
        send_pixel(rtsp_pkg::pixel_t'(32'h1111_1111));
        wait_idle();
        // luma threshold edges, one full byte then a padded row end
        set_format(rtsp_pkg::MODE_GRAY1, 10);
        send_pixel(rtsp_pkg::pixel_t'(32'h8080_8000));
        send_pixel(rtsp_pkg::pixel_t'(32'h7F7F_7FFF));
        send_pixel(rtsp_pkg::pixel_t'(32'hFFFF_FF00));
        send_pixel(rtsp_pkg::pixel_t'(32'h0000_00FF));
        send_pixel(rtsp_pkg::pixel_t'(32'hFF00_0000));
        send_pixel(rtsp_pkg::pixel_t'(32'h00FF_0000));
        send_pixel(rtsp_pkg::pixel_t'(32'h0000_FF00));
        send_pixel(rtsp_pkg::pixel_t'(32'h8080_7F00));
        send_pixel(rtsp_pkg::pixel_t'(32'hFFFF_FFFF));
        send_pixel(rtsp_pkg::pixel_t'(32'h8080_8080));
        set_format(rtsp_pkg::MODE_PALETTE4, 3);
        send_pixel(rtsp_pkg::pixel_t'(32'h1F00_0000));
        send_pixel(rtsp_pkg::pixel_t'(32'hE2FF_FFFF));
        send_pixel(rtsp_pkg::pixel_t'(32'h7C12_3456));
        set_format(rtsp_pkg::MODE_PALETTE8, 1);
        send_pixel(rtsp_pkg::pixel_t'(32'hAB00_0000));
        wait_idle();

        // width zero, a saturated width and the longest row width
        run_phase(rtsp_pkg::MODE_PALETTE4, 0, 20);
        run_phase(rtsp_pkg::MODE_RGBA, 8191, 30);
        run_phase(rtsp_pkg::MODE_GRAY1, MAX_WIDTH, 30);
        while (pixels_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 9) == 0)
                mode = rtsp_pkg::MODE_W'($urandom_range(rtsp_pkg::MODE_PALETTE4 + 1, 7));
            else
                mode = rtsp_pkg::MODE_W'($urandom_range(rtsp_pkg::MODE_RGBA,
                                                        rtsp_pkg::MODE_PALETTE4));
            case ($urandom_range(0, 9))
                0:       width = 0;
                1:       width = $urandom_range(MAX_WIDTH, 8191);
                2, 3:    width = $urandom_range(17, 300);
                default: width = $urandom_range(1, 16);
            endcase
            count   = (mode > rtsp_pkg::MODE_PALETTE4) ? $urandom_range(1, 4)
                                                       : $urandom_range(8, 48);
            no_gaps = ($urandom_range(0, 3) == 0);
            run_phase(mode, width, count);
        end

        if (failures == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/rtsp_pkg.sv
rtl/rtsp_stream_if.sv
rtl/rtsp_cfg_regs.sv
rtl/rtsp_in_stage.sv
rtl/rtsp_pack.sv
rtl/rgba_to_tiff_sample_packer_top.sv
verif/rgba_to_tiff_sample_packer_checker.sv
verif/rgba_to_tiff_sample_packer_top_tb.sv
